### hw/rtl/vcrtu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vcrtu_pkg;

    // field and register widths
    localparam int MODE_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 10;
    localparam int CNT_W     = 11;
    localparam int LINE_W    = 10;
    localparam int SAMPLE_W  = 16;
    localparam int VOL_W     = 4;
    localparam int REG_COUNT = 256;
    localparam int ADDR_W    = $clog2(REG_COUNT);
    localparam int CFG_IDX_W = 2;

    // beam x scaling: count * LINE_WIDTH / cycles_per_line
    localparam int LINE_WIDTH = 160;
    localparam int PROD_W     = CNT_W + $clog2(LINE_WIDTH + 1);
    localparam int DIV_CNT_W  = $clog2(PROD_W + 1);

    localparam logic [CNT_W-1:0]    COUNT_MAX   = CNT_W'(2047);
    localparam logic [SAMPLE_W-1:0] SAMPLE_STEP = SAMPLE_W'(2184);

    // mode codes
    typedef enum logic [MODE_W-1:0] {
        MODE_TICK  = 2'd0,
        MODE_WRITE = 2'd1,
        MODE_READ  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LINES_PER_FRAME = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VBLANK_FIRST    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLES_PER_LINE = 2'd2;

    localparam logic [CFG_W-1:0] RST_LINES_PER_FRAME = CFG_W'(262);
    localparam logic [CFG_W-1:0] RST_VBLANK_FIRST    = CFG_W'(243);
    localparam logic [CFG_W-1:0] RST_CYCLES_PER_LINE = CFG_W'(228);

    // register map
    localparam logic [ADDR_W-1:0] ADDR_CONTROL    = 8'hA0;
    localparam logic [ADDR_W-1:0] ADDR_STATUS     = 8'hA1;
    localparam logic [ADDR_W-1:0] ADDR_COLLISION  = 8'hA2;
    localparam logic [ADDR_W-1:0] ADDR_BEAM_Y     = 8'hA4;
    localparam logic [ADDR_W-1:0] ADDR_BEAM_X     = 8'hA5;
    localparam logic [ADDR_W-1:0] ADDR_SOUND0     = 8'hA7;
    localparam logic [ADDR_W-1:0] ADDR_SOUND_CTRL = 8'hAA;

    // bit positions
    localparam int CTRL_LATCH_BIT  = 1;
    localparam int ST_HBLANK_BIT   = 0;
    localparam int ST_STROBE_BIT   = 1;
    localparam int ST_SOUND_BIT    = 2;
    localparam int ST_VBLANK_BIT   = 3;
    localparam logic [BYTE_W-1:0] ST_KEEP_MASK = 8'hC4;
    localparam int SND_ENABLE_BIT  = 7;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_LINE,
        S_DSTART,
        S_DIV,
        S_FIN,
        S_WR,
        S_RD,
        S_RD_DONE,
        S_OUT
    } t_state;

    // divider handshake back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

### hw/rtl/vcrtu_div.sv
`timescale 1ns / 1ps
`default_nettype none

module vcrtu_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [vcrtu_pkg::PROD_W-1:0]  i_dividend,
    input  wire logic [vcrtu_pkg::CFG_W-1:0]   i_divisor,
    output logic      [vcrtu_pkg::BYTE_W-1:0]  o_quot,
    output vcrtu_pkg::t_div_stat               o_stat
);

    logic                              r_busy;
    logic                              r_done;
    logic [vcrtu_pkg::DIV_CNT_W-1:0]   r_cnt;
    logic [vcrtu_pkg::CFG_W-1:0]       r_rem;
    logic [vcrtu_pkg::PROD_W-1:0]      r_num;
    logic [vcrtu_pkg::CFG_W-1:0]       r_dvs;
    logic [vcrtu_pkg::BYTE_W-1:0]      r_quot;

    logic [vcrtu_pkg::CFG_W:0]         trial;
    logic [vcrtu_pkg::CFG_W:0]         diff;
    logic                              fits;

    // one restoring step: bring down the next dividend bit
    assign trial = {r_rem, r_num[vcrtu_pkg::PROD_W-1]};
    assign fits  = trial >= {1'b0, r_dvs};
    assign diff  = trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= vcrtu_pkg::DIV_CNT_W'(vcrtu_pkg::PROD_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == vcrtu_pkg::DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_num  <= i_dividend;
            r_dvs  <= i_divisor;
            r_quot <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[vcrtu_pkg::PROD_W-2:0], 1'b0};
            r_rem  <= fits ? diff[vcrtu_pkg::CFG_W-1:0] : trial[vcrtu_pkg::CFG_W-1:0];
            r_quot <= {r_quot[vcrtu_pkg::BYTE_W-2:0], fits};
        end
    end

    assign o_quot      = r_quot;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

`default_nettype wire

### hw/rtl/video_chip_register_timing_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// sequence: a tick runs the add, line, divider start, divider and finish states, a write
//   its write state, a read its read and read done states, then output; unused mode goes
//   straight to output; the beam x divider makes one quotient bit per cycle; one word is
//   in flight and the next is accepted after output, which waits while the master stalls
// reset (synchronous, active low) clears the register file through per-entry
//   valid bits at once, loads default timing and drops the output word

module video_chip_register_timing_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // slave side: mode[1:0], cycle_count[9:2], reg_address[17:10],
    // write_data[25:18], zero pad [31:26]
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,
    // master side: read_data[7:0], audio_sample[23:8]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic      [23:0] o_m_axis_tdata,
    // timing configuration
    input  wire logic                                i_cfg_we,
    input  wire logic [vcrtu_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [vcrtu_pkg::CFG_W-1:0]         i_cfg_data
);

    localparam int BW = vcrtu_pkg::BYTE_W;
    localparam int AW = vcrtu_pkg::ADDR_W;

    // sequencer
    vcrtu_pkg::t_state r_state, n_state;

    // captured word
    vcrtu_pkg::t_mode  r_mode;
    logic [BW-1:0]     r_cyc;
    logic [AW-1:0]     r_addr;
    logic [BW-1:0]     r_wdata;

    // timing configuration
    logic [vcrtu_pkg::CFG_W-1:0] r_lpf;
    logic [vcrtu_pkg::CFG_W-1:0] r_vfl;
    logic [vcrtu_pkg::CFG_W-1:0] r_cpl;

    // beam state
    logic [vcrtu_pkg::CNT_W-1:0]  r_cnt;
    logic [vcrtu_pkg::LINE_W-1:0] r_line;
    logic [BW-1:0]                r_beam_line;
    logic                         r_adv;

    // registers that the timing logic touches live in flops
    logic [BW-1:0] r_ctrl;
    logic [BW-1:0] r_stat;
    logic [BW-1:0] r_coll;
    logic [BW-1:0] r_beam_y;
    logic [BW-1:0] r_beam_x;
    logic [BW-1:0] r_snd0;
    logic                          r_snd_on;
    logic [vcrtu_pkg::VOL_W-1:0]   r_snd_vol;

    // general register file
    logic [BW-1:0]                     r_mem [vcrtu_pkg::REG_COUNT];
    logic [vcrtu_pkg::REG_COUNT-1:0]   r_valid;
    logic [BW-1:0]                     r_mem_q;
    logic                              r_mem_vq;
    logic [BW-1:0]                     r_rd;

    // output register
    logic                              r_out_valid;
    logic [BW-1:0]                     r_out_rd;
    logic [vcrtu_pkg::SAMPLE_W-1:0]    r_out_sample;

    // control strobes from the sequencer
    logic in_accept;
    logic out_free;
    logic div_start;
    logic out_load;

    // divider
    logic [vcrtu_pkg::PROD_W-1:0] product;
    logic [BW-1:0]                quot;
    vcrtu_pkg::t_div_stat         div_stat;

    // tick datapath
    logic [vcrtu_pkg::CNT_W:0]    cnt_sum;
    logic [vcrtu_pkg::CNT_W-1:0]  cnt_sat;
    logic [vcrtu_pkg::CFG_W:0]    line_inc;
    logic [vcrtu_pkg::CFG_W+1:0]  cpl_x3;
    logic [vcrtu_pkg::CFG_W-1:0]  hb_thr;
    logic                         latched;
    logic [BW-1:0]                bx;
    logic [BW-1:0]                st_new;
    logic [BW-1:0]                rd_mux;
    logic [vcrtu_pkg::SAMPLE_W-1:0] mag;
    logic [vcrtu_pkg::SAMPLE_W-1:0] sample;

    assign in_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign out_free  = !r_out_valid || i_m_axis_tready;

    // ------------------------------------------------------------------
    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            vcrtu_pkg::S_IDLE: begin
                if (i_s_axis_tvalid) begin
                    unique case (vcrtu_pkg::t_mode'(i_s_axis_tdata[1:0]))
                        vcrtu_pkg::MODE_TICK:  n_state = vcrtu_pkg::S_ADD;
                        vcrtu_pkg::MODE_WRITE: n_state = vcrtu_pkg::S_WR;
                        vcrtu_pkg::MODE_READ:  n_state = vcrtu_pkg::S_RD;
                        default:               n_state = vcrtu_pkg::S_OUT;
                    endcase
                end
            end
            vcrtu_pkg::S_ADD:     n_state = vcrtu_pkg::S_LINE;
            vcrtu_pkg::S_LINE:    n_state = vcrtu_pkg::S_DSTART;
            vcrtu_pkg::S_DSTART:  n_state = vcrtu_pkg::S_DIV;
            vcrtu_pkg::S_DIV: begin
                if (div_stat.done) begin
                    n_state = vcrtu_pkg::S_FIN;
                end
            end
            vcrtu_pkg::S_FIN:     n_state = vcrtu_pkg::S_OUT;
            vcrtu_pkg::S_WR:      n_state = vcrtu_pkg::S_OUT;
            vcrtu_pkg::S_RD:      n_state = vcrtu_pkg::S_RD_DONE;
            vcrtu_pkg::S_RD_DONE: n_state = vcrtu_pkg::S_OUT;
            vcrtu_pkg::S_OUT: begin
                if (out_free) begin
                    n_state = vcrtu_pkg::S_IDLE;
                end
            end
            default:              n_state = vcrtu_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        div_start       = 1'b0;
        out_load        = 1'b0;
        unique case (r_state)
            vcrtu_pkg::S_IDLE:   o_s_axis_tready = 1'b1;
            vcrtu_pkg::S_DSTART: div_start = 1'b1;
            vcrtu_pkg::S_OUT:    out_load = out_free;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vcrtu_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // ------------------------------------------------------------------
    // capture the incoming word
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_mode  <= vcrtu_pkg::t_mode'(i_s_axis_tdata[1:0]);
            r_cyc   <= i_s_axis_tdata[9:2];
            r_addr  <= i_s_axis_tdata[17:10];
            r_wdata <= i_s_axis_tdata[25:18];
        end
    end

    // configuration writes, indexes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpf <= vcrtu_pkg::RST_LINES_PER_FRAME;
            r_vfl <= vcrtu_pkg::RST_VBLANK_FIRST;
            r_cpl <= vcrtu_pkg::RST_CYCLES_PER_LINE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                vcrtu_pkg::CFG_LINES_PER_FRAME: r_lpf <= i_cfg_data;
                vcrtu_pkg::CFG_VBLANK_FIRST:    r_vfl <= i_cfg_data;
                vcrtu_pkg::CFG_CYCLES_PER_LINE: r_cpl <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // tick arithmetic
    assign cnt_sum  = {1'b0, r_cnt} + {{(vcrtu_pkg::CNT_W + 1 - BW){1'b0}}, r_cyc};
    assign cnt_sat  = cnt_sum[vcrtu_pkg::CNT_W] ? vcrtu_pkg::COUNT_MAX
                                                : cnt_sum[vcrtu_pkg::CNT_W-1:0];
    assign line_inc = {1'b0, r_line} + 1'b1;

    // count * LINE_WIDTH (160) as a constant multiply
    assign product = {{(vcrtu_pkg::PROD_W - vcrtu_pkg::CNT_W){1'b0}}, r_cnt}
                     * vcrtu_pkg::PROD_W'(vcrtu_pkg::LINE_WIDTH);

    // hblank threshold: three quarters of the line, rounded down
    assign cpl_x3 = {1'b0, r_cpl, 1'b0} + {2'b00, r_cpl};
    assign hb_thr = cpl_x3[vcrtu_pkg::CFG_W+1:2];

    assign latched = r_ctrl[vcrtu_pkg::CTRL_LATCH_BIT];
    assign bx      = (r_cpl == '0) ? '0 : quot;

    always_comb begin
        st_new = r_stat & vcrtu_pkg::ST_KEEP_MASK;
        st_new[vcrtu_pkg::ST_HBLANK_BIT] = {1'b0, r_cnt} > {2'b00, hb_thr};
        st_new[vcrtu_pkg::ST_VBLANK_BIT] = r_line >= r_vfl;
        st_new[vcrtu_pkg::ST_STROBE_BIT] = !latched;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_line      <= '0;
            r_beam_line <= '0;
            r_adv       <= 1'b0;
        end else begin
            unique case (r_state)
                vcrtu_pkg::S_ADD: begin
                    r_cnt <= cnt_sat;
                end
                vcrtu_pkg::S_LINE: begin
                    r_adv <= {1'b0, r_cnt} >= {1'b0, r_cpl};
                    if ({1'b0, r_cnt} >= {1'b0, r_cpl}) begin
                        r_cnt <= r_cnt - {1'b0, r_cpl};
                        // an advance at or past frame end wraps to line zero
                        if (line_inc >= {1'b0, r_lpf}) begin
                            r_line <= '0;
                        end else begin
                            r_line <= line_inc[vcrtu_pkg::LINE_W-1:0];
                        end
                    end
                end
                vcrtu_pkg::S_DSTART: begin
                    if (r_adv && (r_line < r_vfl)) begin
                        r_beam_line <= r_line[BW-1:0];
                    end
                end
                default: begin
                end
            endcase
        end
    end

    vcrtu_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (product),
        .i_divisor  (r_cpl),
        .o_quot     (quot),
        .o_stat     (div_stat)
    );

    // ------------------------------------------------------------------
    // register file: general entries in memory, timing registers in flops
    always_ff @(posedge i_clk) begin
        if (r_state == vcrtu_pkg::S_WR) begin
            r_mem[r_addr] <= r_wdata;
        end
        if (r_state == vcrtu_pkg::S_RD) begin
            r_mem_q <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_mem_vq <= 1'b0;
        end else begin
            if (r_state == vcrtu_pkg::S_WR) begin
                r_valid[r_addr] <= 1'b1;
            end
            if (r_state == vcrtu_pkg::S_RD) begin
                r_mem_vq <= r_valid[r_addr];
            end
        end
    end

    // read source select
    always_comb begin
        unique case (r_addr)
            vcrtu_pkg::ADDR_CONTROL:   rd_mux = r_ctrl;
            vcrtu_pkg::ADDR_STATUS:    rd_mux = r_stat;
            vcrtu_pkg::ADDR_COLLISION: rd_mux = r_coll;
            vcrtu_pkg::ADDR_BEAM_Y:    rd_mux = r_beam_y;
            vcrtu_pkg::ADDR_BEAM_X:    rd_mux = r_beam_x;
            vcrtu_pkg::ADDR_SOUND0:    rd_mux = r_snd0;
            default:                   rd_mux = r_mem_vq ? r_mem_q : '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl    <= '0;
            r_stat    <= '0;
            r_coll    <= '0;
            r_beam_y  <= '0;
            r_beam_x  <= '0;
            r_snd0    <= '0;
            r_snd_on  <= 1'b0;
            r_snd_vol <= '0;
            r_rd      <= '0;
        end else begin
            unique case (r_state)
                vcrtu_pkg::S_FIN: begin
                    r_rd   <= '0;
                    r_stat <= st_new;
                    if (!latched) begin
                        r_beam_y <= r_beam_line;
                        r_beam_x <= bx;
                    end
                end
                vcrtu_pkg::S_WR: begin
                    r_rd <= '0;
                    unique case (r_addr)
                        vcrtu_pkg::ADDR_CONTROL:   r_ctrl   <= r_wdata;
                        vcrtu_pkg::ADDR_STATUS:    r_stat   <= r_wdata;
                        vcrtu_pkg::ADDR_COLLISION: r_coll   <= r_wdata;
                        vcrtu_pkg::ADDR_BEAM_Y:    r_beam_y <= r_wdata;
                        vcrtu_pkg::ADDR_BEAM_X:    r_beam_x <= r_wdata;
                        vcrtu_pkg::ADDR_SOUND0:    r_snd0   <= r_wdata;
                        vcrtu_pkg::ADDR_SOUND_CTRL: begin
                            r_snd_on  <= r_wdata[vcrtu_pkg::SND_ENABLE_BIT];
                            r_snd_vol <= r_wdata[vcrtu_pkg::VOL_W-1:0];
                        end
                        default: begin
                        end
                    endcase
                end
                vcrtu_pkg::S_RD_DONE: begin
                    r_rd <= rd_mux;
                    // clear on read
                    if (r_addr == vcrtu_pkg::ADDR_STATUS) begin
                        r_stat[vcrtu_pkg::ST_SOUND_BIT] <= 1'b0;
                    end else if (r_addr == vcrtu_pkg::ADDR_COLLISION) begin
                        r_coll <= '0;
                    end
                end
                vcrtu_pkg::S_IDLE: begin
                    if (in_accept) begin
                        r_rd <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // audio: +/- volume * step, sign from sound byte 0 bit 0
    assign mag    = {{(vcrtu_pkg::SAMPLE_W - vcrtu_pkg::VOL_W){1'b0}}, r_snd_vol}
                    * vcrtu_pkg::SAMPLE_STEP;
    assign sample = !r_snd_on ? '0 : (r_snd0[0] ? mag : ('0 - mag));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_rd     <= (r_mode == vcrtu_pkg::MODE_READ) ? r_rd : '0;
            r_out_sample <= sample;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out_sample, r_out_rd};

endmodule

`default_nettype wire

### hw/rtl/vcrtu_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module vcrtu_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_axis_tvalid,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [23:0] o_m_axis_tdata
);

    // reset empties the output side
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    // one word at a time: busy right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("ready right after accept");

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled result changed");

    // audio stays within volume range
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            ($signed(o_m_axis_tdata[23:8]) <= 16'sd32760 &&
             $signed(o_m_axis_tdata[23:8]) >= -16'sd32760))
        else $error("audio sample out of range");

endmodule

bind video_chip_register_timing_unit vcrtu_checker u_vcrtu_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

`default_nettype wire

### verif/tb_video_chip_register_timing_unit.sv
`timescale 1ns / 1ps

module tb_video_chip_register_timing_unit;

    localparam int              CYCLE_LIMIT     = 400000;
    localparam int              IDLE_PCT        = 11;
    localparam int              WORDS_PER_PHASE = 135;
    // index past the timing registers, the block must ignore it
    localparam logic [vcrtu_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // one bus access or tick as it travels on the slave side
    typedef struct packed {
        logic [vcrtu_pkg::BYTE_W-1:0] write_data;
        logic [vcrtu_pkg::BYTE_W-1:0] reg_address;
        logic [vcrtu_pkg::BYTE_W-1:0] cycle_count;
        vcrtu_pkg::t_mode             mode;
    } t_bus_word;

    // one result word as it leaves the master side
    typedef struct packed {
        logic [vcrtu_pkg::SAMPLE_W-1:0] audio_sample;
        logic [vcrtu_pkg::BYTE_W-1:0]   read_data;
    } t_result_word;

    // register file and beam timing tracker plus the queue of expected results
    class beam_timing_scoreboard;
        logic [vcrtu_pkg::BYTE_W-1:0] regs [vcrtu_pkg::REG_COUNT];
        logic [vcrtu_pkg::CNT_W-1:0]  line_count;
        logic [vcrtu_pkg::LINE_W-1:0] scan_line;
        logic [vcrtu_pkg::BYTE_W-1:0] beam_y;
        logic                         snd_on;
        logic [vcrtu_pkg::VOL_W-1:0]  snd_vol;
        logic [vcrtu_pkg::CFG_W-1:0]  frame_lines;
        logic [vcrtu_pkg::CFG_W-1:0]  vblank_line;
        logic [vcrtu_pkg::CFG_W-1:0]  line_cycles;
        t_result_word                 expected_q [$];
        int                           errors;
        int                           checked;
        int                           vblank_ticks;

        function new();
            foreach (regs[i]) regs[i] = '0;
            line_count   = '0;
            scan_line    = '0;
            beam_y       = '0;
            snd_on       = 1'b0;
            snd_vol      = '0;
            frame_lines  = vcrtu_pkg::RST_LINES_PER_FRAME;
            vblank_line  = vcrtu_pkg::RST_VBLANK_FIRST;
            line_cycles  = vcrtu_pkg::RST_CYCLES_PER_LINE;
            errors       = 0;
            checked      = 0;
            vblank_ticks = 0;
        endfunction

        function void set_timing(logic [vcrtu_pkg::CFG_IDX_W-1:0] idx,
                                 logic [vcrtu_pkg::CFG_W-1:0] val);
            case (idx)
                vcrtu_pkg::CFG_LINES_PER_FRAME: frame_lines = val;
                vcrtu_pkg::CFG_VBLANK_FIRST:    vblank_line = val;
                vcrtu_pkg::CFG_CYCLES_PER_LINE: line_cycles = val;
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // update the register file for an accepted word and queue its result
        function void note_word(t_bus_word w);
            int unsigned                  cnt;
            int unsigned                  next_line;
            int unsigned                  beam_x;
            int unsigned                  mag;
            logic                         latched;
            logic [vcrtu_pkg::BYTE_W-1:0] st;
            t_result_word                 exp_r;
            exp_r.read_data = '0;
            case (w.mode)
                vcrtu_pkg::MODE_TICK: begin
                    cnt = line_count + w.cycle_count;
                    if (cnt > vcrtu_pkg::COUNT_MAX) cnt = vcrtu_pkg::COUNT_MAX;
                    // end of line: take one line length off, step the scanline
                    if (cnt >= line_cycles) begin
                        cnt       = cnt - line_cycles;
                        next_line = scan_line + 1;
                        if (next_line >= frame_lines) next_line = 0;
                        scan_line = vcrtu_pkg::LINE_W'(next_line);
                        if (scan_line < vblank_line)
                            beam_y = scan_line[vcrtu_pkg::BYTE_W-1:0];
                    end
                    line_count = vcrtu_pkg::CNT_W'(cnt);
                    beam_x = (line_cycles != 0) ?
                             (cnt * vcrtu_pkg::LINE_WIDTH) / line_cycles : 0;
                    latched = regs[vcrtu_pkg::ADDR_CONTROL][vcrtu_pkg::CTRL_LATCH_BIT];
                    if (!latched) begin
                        regs[vcrtu_pkg::ADDR_BEAM_Y] = beam_y;
                        regs[vcrtu_pkg::ADDR_BEAM_X] = beam_x[vcrtu_pkg::BYTE_W-1:0];
                    end
                    st = regs[vcrtu_pkg::ADDR_STATUS] & vcrtu_pkg::ST_KEEP_MASK;
                    st[vcrtu_pkg::ST_HBLANK_BIT] = cnt > (line_cycles * 3) / 4;
                    st[vcrtu_pkg::ST_VBLANK_BIT] = scan_line >= vblank_line;
                    st[vcrtu_pkg::ST_STROBE_BIT] = !latched;
                    regs[vcrtu_pkg::ADDR_STATUS] = st;
                    if (st[vcrtu_pkg::ST_VBLANK_BIT]) vblank_ticks++;
                end
                vcrtu_pkg::MODE_WRITE: begin
                    regs[w.reg_address] = w.write_data;
                    if (w.reg_address == vcrtu_pkg::ADDR_SOUND_CTRL) begin
                        snd_on  = w.write_data[vcrtu_pkg::SND_ENABLE_BIT];
                        snd_vol = w.write_data[vcrtu_pkg::VOL_W-1:0];
                    end
                end
                vcrtu_pkg::MODE_READ: begin
                    exp_r.read_data = regs[w.reg_address];
                    if (w.reg_address == vcrtu_pkg::ADDR_STATUS)
                        regs[vcrtu_pkg::ADDR_STATUS][vcrtu_pkg::ST_SOUND_BIT] = 1'b0;
                    else if (w.reg_address == vcrtu_pkg::ADDR_COLLISION)
                        regs[vcrtu_pkg::ADDR_COLLISION] = '0;
                end
                default: ;
            endcase
            mag = snd_vol * vcrtu_pkg::SAMPLE_STEP;
            if (!snd_on)
                exp_r.audio_sample = '0;
            else if (regs[vcrtu_pkg::ADDR_SOUND0][0])
                exp_r.audio_sample = vcrtu_pkg::SAMPLE_W'(mag);
            else
                exp_r.audio_sample = vcrtu_pkg::SAMPLE_W'(0 - mag);
            expected_q.push_back(exp_r);
        endfunction

        function void check_word(t_result_word got);
            t_result_word exp_r;
            checked++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, read_data %h audio_sample %0d",
                         $time, got.read_data, $signed(got.audio_sample));
                return;
            end
            exp_r = expected_q.pop_front();
            if (got.read_data !== exp_r.read_data) begin
                errors++;
                $display("%0t: read_data expected %h got %h",
                         $time, exp_r.read_data, got.read_data);
            end
            if (got.audio_sample !== exp_r.audio_sample) begin
                errors++;
                $display("%0t: audio_sample expected %0d got %0d",
                         $time, $signed(exp_r.audio_sample), $signed(got.audio_sample));
            end
        endfunction
    endclass

    logic                            i_clk           = 1'b0;
    logic                            i_rst_n         = 1'b0;
    logic                            i_s_axis_tvalid = 1'b0;
    logic                            o_s_axis_tready;
    // mode[1:0], cycle_count[9:2], reg_address[17:10], write_data[25:18], pad
    logic [31:0]                     i_s_axis_tdata  = '0;
    logic                            o_m_axis_tvalid;
    logic                            i_m_axis_tready = 1'b0;
    // read_data[7:0], audio_sample[23:8]
    logic [23:0]                     o_m_axis_tdata;
    logic                            i_cfg_we        = 1'b0;
    logic [vcrtu_pkg::CFG_IDX_W-1:0] i_cfg_index     = '0;
    logic [vcrtu_pkg::CFG_W-1:0]     i_cfg_data      = '0;

    beam_timing_scoreboard sb = new();
    // suppresses idling on both sides for one whole phase
    bit                    calm           = 1'b0;
    int                    cycle_count    = 0;
    int                    timing_changes = 0;

    video_chip_register_timing_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // result side stalls now and then except in the calm phase
    always @(negedge i_clk) begin
        i_m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    // every result word accepted at a rising edge goes to the scoreboard
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_word(t_result_word'(o_m_axis_tdata));
    end

    function automatic t_bus_word bus_word(vcrtu_pkg::t_mode m, logic [7:0] cycles,
                                           logic [7:0] addr, logic [7:0] data);
        t_bus_word w;
        w.mode        = m;
        w.cycle_count = cycles;
        w.reg_address = addr;
        w.write_data  = data;
        return w;
    endfunction

    // starts at a falling edge, returns at the rising edge that took the word;
    // valid is left high for the next word and drops only for a random idle outside calm
    task automatic send_word(input t_bus_word w);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            i_s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, w.write_data, w.reg_address, w.cycle_count, w.mode};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        sb.note_word(w);
    endtask

    task automatic stop_words();
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic program_timing(input logic [vcrtu_pkg::CFG_IDX_W-1:0] idx,
                                  input logic [vcrtu_pkg::CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        sb.set_timing(idx, val);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // timing changes only land while nothing is in flight
    task automatic retime(input logic [vcrtu_pkg::CFG_W-1:0] frame,
                          input logic [vcrtu_pkg::CFG_W-1:0] vbl,
                          input logic [vcrtu_pkg::CFG_W-1:0] cycles);
        stop_words();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        program_timing(vcrtu_pkg::CFG_LINES_PER_FRAME, frame);
        program_timing(vcrtu_pkg::CFG_VBLANK_FIRST, vbl);
        program_timing(vcrtu_pkg::CFG_CYCLES_PER_LINE, cycles);
        timing_changes++;
    endtask

    // mostly ticks and accesses around the chip registers, some stray addresses
    task automatic run_random(input int n);
        t_bus_word w;
        int        pick;
        repeat (n) begin
            pick          = $urandom_range(0, 99);
            w.mode        = (pick < 45) ? vcrtu_pkg::MODE_TICK  :
                            (pick < 72) ? vcrtu_pkg::MODE_WRITE :
                            (pick < 96) ? vcrtu_pkg::MODE_READ  : vcrtu_pkg::MODE_NONE;
            w.cycle_count = vcrtu_pkg::BYTE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
                w.cycle_count = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            w.write_data  = vcrtu_pkg::BYTE_W'($urandom_range(0, 255));
            w.reg_address = vcrtu_pkg::BYTE_W'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 65) begin
                case ($urandom_range(0, 8))
                    0: w.reg_address = vcrtu_pkg::ADDR_CONTROL;
                    1: w.reg_address = vcrtu_pkg::ADDR_STATUS;
                    2: w.reg_address = vcrtu_pkg::ADDR_COLLISION;
                    3: w.reg_address = vcrtu_pkg::ADDR_BEAM_Y;
                    4: w.reg_address = vcrtu_pkg::ADDR_BEAM_X;
                    5: w.reg_address = vcrtu_pkg::ADDR_SOUND0;
                    6: w.reg_address = vcrtu_pkg::ADDR_SOUND0 + 8'd1;
                    7: w.reg_address = vcrtu_pkg::ADDR_SOUND0 + 8'd2;
                    default: w.reg_address = vcrtu_pkg::ADDR_SOUND_CTRL;
                endcase
            end
            send_word(w);
        end
    endtask

    initial begin
        // synchronous reset, released at a falling edge
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed words under the reset timing
        send_word(bus_word(vcrtu_pkg::MODE_TICK,  8'h00, 8'h00, 8'h00));
        send_word(bus_word(vcrtu_pkg::MODE_TICK,  8'hFF, 8'h00, 8'h00));
        // unused mode with every field set, nothing may change
        send_word(bus_word(vcrtu_pkg::MODE_NONE,  8'hFF, 8'hFF, 8'hFF));
        // full volume, positive then negative sample
        send_word(bus_word(vcrtu_pkg::MODE_WRITE, 8'h00, vcrtu_pkg::ADDR_SOUND_CTRL, 8'h8F));
        send_word(bus_word(vcrtu_pkg::MODE_WRITE, 8'h00, vcrtu_pkg::ADDR_SOUND0, 8'h01));
        send_word(bus_word(vcrtu_pkg::MODE_TICK,  8'hC8, 8'h00, 8'h00));
        send_word(bus_word(vcrtu_pkg::MODE_WRITE, 8'h00, vcrtu_pkg::ADDR_SOUND0, 8'h00));
        send_word(bus_word(vcrtu_pkg::MODE_READ,  8'h00, vcrtu_pkg::ADDR_BEAM_X, 8'h00));
        send_word(bus_word(vcrtu_pkg::MODE_READ,  8'h00, vcrtu_pkg::ADDR_BEAM_Y, 8'h00));
        // sticky status bits survive a tick, sound service clears on read
        send_word(bus_word(vcrtu_pkg::MODE_WRITE, 8'h00, vcrtu_pkg::ADDR_STATUS,
                           vcrtu_pkg::ST_KEEP_MASK));
        send_word(bus_word(vcrtu_pkg::MODE_TICK,  8'hFF, 8'h00, 8'h00));
        send_word(bus_word(vcrtu_pkg::MODE_READ,  8'h00, vcrtu_pkg::ADDR_STATUS, 8'h00));
        send_word(bus_word(vcrtu_pkg::MODE_READ,  8'h00, vcrtu_pkg::ADDR_STATUS, 8'h00));
        // collision clears on read
        send_word(bus_word(vcrtu_pkg::MODE_WRITE, 8'h00, vcrtu_pkg::ADDR_COLLISION, 8'hFF));
        send_word(bus_word(vcrtu_pkg::MODE_READ,  8'h00, vcrtu_pkg::ADDR_COLLISION, 8'h00));
        send_word(bus_word(vcrtu_pkg::MODE_READ,  8'h00, vcrtu_pkg::ADDR_COLLISION, 8'h00));
        // latch freezes beam x and y and drops the strobe
        send_word(bus_word(vcrtu_pkg::MODE_WRITE, 8'h00, vcrtu_pkg::ADDR_CONTROL, 8'h02));
        send_word(bus_word(vcrtu_pkg::MODE_TICK,  8'h64, 8'h00, 8'h00));
        send_word(bus_word(vcrtu_pkg::MODE_READ,  8'h00, vcrtu_pkg::ADDR_BEAM_X, 8'h00));
        send_word(bus_word(vcrtu_pkg::MODE_WRITE, 8'h00, vcrtu_pkg::ADDR_CONTROL, 8'h00));
        // plain storage at both ends of the address range
        send_word(bus_word(vcrtu_pkg::MODE_WRITE, 8'h00, 8'h00, 8'h55));
        send_word(bus_word(vcrtu_pkg::MODE_READ,  8'h00, 8'h00, 8'h00));
        send_word(bus_word(vcrtu_pkg::MODE_WRITE, 8'h00, 8'hFF, 8'hAA));
        send_word(bus_word(vcrtu_pkg::MODE_READ,  8'h00, 8'hFF, 8'h00));
        send_word(bus_word(vcrtu_pkg::MODE_WRITE, 8'h00, vcrtu_pkg::ADDR_SOUND_CTRL, 8'h00));
        run_random(100);

        // short frames so vertical blank and frame wrap come around often
        retime(10'd12, 10'd9, 10'd100);
        run_random(WORDS_PER_PHASE);
        // one-line frame and a line length of one, beam x overflows 8 bits
        retime(10'd1, 10'd0, 10'd1);
        run_random(WORDS_PER_PHASE);
        // zero frame and zero line length, the counter saturates
        retime(10'd0, 10'd1023, 10'd0);
        run_random(WORDS_PER_PHASE);
        retime(10'd1023, 10'd1023, 10'd1023);
        run_random(WORDS_PER_PHASE);
        // no idling on either side for this phase
        calm = 1'b1;
        retime(10'd6, 10'd3, 10'd37);
        run_random(WORDS_PER_PHASE);
        calm = 1'b0;
        repeat (2) begin
            retime(vcrtu_pkg::CFG_W'($urandom_range(1, 40)),
                   vcrtu_pkg::CFG_W'($urandom_range(0, 40)),
                   vcrtu_pkg::CFG_W'($urandom_range(1, 300)));
            program_timing(CFG_UNUSED_IDX, vcrtu_pkg::CFG_W'($urandom_range(0, 1023)));
            run_random(WORDS_PER_PHASE);
        end

        stop_words();
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("%0d results checked over %0d timing settings after the reset one,",
                 sb.checked, timing_changes);
        $display("%0d ticks ended in vertical blank", sb.vblank_ticks);
        if (sb.errors == 0)
            $display("tb_video_chip_register_timing_unit: done, clean");
        else
            $display("tb_video_chip_register_timing_unit: done, errors");
        $finish;
    end

    // run time guard
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: cycle limit reached with %0d results outstanding",
                 $time, sb.pending());
        $display("tb_video_chip_register_timing_unit: done, errors");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/vcrtu_pkg.sv
hw/rtl/vcrtu_div.sv
hw/rtl/video_chip_register_timing_unit.sv
hw/rtl/vcrtu_checker.sv
verif/tb_video_chip_register_timing_unit.sv
